### hw/rtl/xosh_pkg.sv
// Package for the xoshiro256** generator: opcodes, sequencer states,
// seed constants and the rotate helper. Depends on nothing.
`default_nettype none

package xosh_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BOUND_W = 32;

    localparam logic [VALUE_W-1:0] SEED_K0 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [VALUE_W-1:0] SEED_K1 = 64'h6C62_272E_07BB_0142;
    localparam logic [VALUE_W-1:0] SEED_K2 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [VALUE_W-1:0] SEED_K3 = 64'h94D0_49BB_1331_11EB;

    // Shift and rotate amounts of the generator.
    localparam int unsigned SCRAMBLE_ROT = 7;
    localparam int unsigned STEP_SHIFT   = 17;
    localparam int unsigned STEP_ROT     = 45;

    // Index of the last dividend bit of the serial remainder loop.
    localparam logic [5:0] DIV_LAST = 6'(VALUE_W - 1);

    typedef enum logic [1:0] {
        OP_SEED    = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCRAMBLE,
        ST_MIX,
        ST_DIVIDE,
        ST_WARM,
        ST_EMIT
    } t_state;

    function automatic logic [VALUE_W-1:0] rotl64(input logic [VALUE_W-1:0] v,
                                                  input int unsigned n);
        rotl64 = (v << n) | (v >> (VALUE_W - n));
    endfunction

endpackage

`default_nettype wire

### hw/rtl/xoshiro256_random_generator.sv
// Top level of the xoshiro256** generator: state words, sequencer,
// scrambler and a bit-serial remainder unit. Depends on xosh_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_op, i_seed_value, i_bound
//   out      source     o_out_valid / i_out_stall o_value
//
// A raw word passes through ST_SCRAMBLE, ST_MIX and ST_EMIT to the output register;
// a bounded word with a nonzero bound also runs the remainder loop in ST_DIVIDE, one
// bit a cycle through a single shared subtractor. A seed word keeps the input
// stalled while WARMUP_STEPS generator steps run; op 3 does not stall it. Reset is
// synchronous and loads the four seed constants with no warm-up. A result held
// back by i_out_stall sits in the output register; the next word's waits in ST_EMIT.
`default_nettype none

module xoshiro256_random_generator #(
    parameter int unsigned WARMUP_STEPS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_seed_value,
    input  wire logic [31:0] i_bound,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [63:0] o_value
);

    localparam int unsigned CNT_W = $clog2(WARMUP_STEPS + 2);

    xosh_pkg::t_state r_state, n_state;
    logic [63:0]      r_s0, r_s1, r_s2, r_s3;
    logic [63:0]      n_s0, n_s1, n_s2, n_s3;
    logic [CNT_W-1:0] r_warm, n_warm;
    logic             r_bounded, n_bounded;
    logic [31:0]      r_div, n_div;
    logic [63:0]      r_prod, n_prod;
    logic [63:0]      r_quo, n_quo;
    logic [31:0]      r_rem, n_rem;
    logic [5:0]       r_bit, n_bit;
    logic [63:0]      r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic [63:0]      r_value, n_value;

    logic        accept;
    logic [63:0] step_s0, step_s1, step_s2, step_s3;
    logic [63:0] rot_prod, scrambled;
    logic [32:0] trial;
    logic [33:0] diff;
    logic [31:0] rem_next;

    assign accept      = i_in_valid && (r_state == xosh_pkg::ST_IDLE);
    assign o_in_stall  = (r_state != xosh_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    // One generator step from the current words.
    always_comb begin
        logic [63:0] t2, t3;
        t2      = r_s2 ^ r_s0;
        t3      = r_s3 ^ r_s1;
        step_s1 = r_s1 ^ t2;
        step_s0 = r_s0 ^ t3;
        step_s2 = t2 ^ (r_s1 << xosh_pkg::STEP_SHIFT);
        step_s3 = xosh_pkg::rotl64(t3, xosh_pkg::STEP_ROT);
    end

    // The times-five and times-nine factors are shift-and-add.
    assign rot_prod  = xosh_pkg::rotl64(r_prod, xosh_pkg::SCRAMBLE_ROT);
    assign scrambled = rot_prod + (rot_prod << 3);

    // Shared subtractor of the restoring remainder loop.
    assign trial    = {r_rem, r_quo[63]};
    assign diff     = {1'b0, trial} - {2'b00, r_div};
    assign rem_next = diff[33] ? trial[31:0] : diff[31:0];

    always_comb begin
        n_state     = r_state;
        n_s0        = r_s0;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_warm      = r_warm;
        n_bounded   = r_bounded;
        n_div       = r_div;
        n_prod      = r_prod;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_value     = r_value;

        unique case (r_state)
            xosh_pkg::ST_IDLE: begin
                if (accept) begin
                    n_bounded = (xosh_pkg::t_op'(i_op) == xosh_pkg::OP_BOUNDED);
                    n_div     = i_bound;
                    unique case (xosh_pkg::t_op'(i_op))
                        xosh_pkg::OP_SEED: begin
                            n_s0   = i_seed_value ^ xosh_pkg::SEED_K0;
                            n_s1   = i_seed_value ^ xosh_pkg::SEED_K1;
                            n_s2   = i_seed_value ^ xosh_pkg::SEED_K2;
                            n_s3   = i_seed_value ^ xosh_pkg::SEED_K3;
                            n_warm = CNT_W'(WARMUP_STEPS);
                            if (WARMUP_STEPS != 0) begin
                                n_state = xosh_pkg::ST_WARM;
                            end
                        end
                        xosh_pkg::OP_RAW,
                        xosh_pkg::OP_BOUNDED: begin
                            n_state = xosh_pkg::ST_SCRAMBLE;
                        end
                        xosh_pkg::OP_NONE: begin
                            n_state = xosh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            xosh_pkg::ST_SCRAMBLE: begin
                n_prod  = r_s1 + (r_s1 << 2);
                n_state = xosh_pkg::ST_MIX;
            end
            xosh_pkg::ST_MIX: begin
                n_s0 = step_s0;
                n_s1 = step_s1;
                n_s2 = step_s2;
                n_s3 = step_s3;
                if (r_bounded && (r_div != '0)) begin
                    n_quo   = scrambled;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_state = xosh_pkg::ST_DIVIDE;
                end else begin
                    n_res   = scrambled;
                    n_state = xosh_pkg::ST_EMIT;
                end
            end
            xosh_pkg::ST_DIVIDE: begin
                n_rem = rem_next;
                n_quo = {r_quo[62:0], 1'b0};
                n_bit = r_bit + 6'd1;
                if (r_bit == xosh_pkg::DIV_LAST) begin
                    n_res   = {32'd0, rem_next};
                    n_state = xosh_pkg::ST_EMIT;
                end
            end
            xosh_pkg::ST_WARM: begin
                n_s0   = step_s0;
                n_s1   = step_s1;
                n_s2   = step_s2;
                n_s3   = step_s3;
                n_warm = r_warm - CNT_W'(1);
                if (r_warm == CNT_W'(1)) begin
                    n_state = xosh_pkg::ST_IDLE;
                end
            end
            xosh_pkg::ST_EMIT: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || !i_out_stall) begin
                    n_value     = r_res;
                    n_out_valid = 1'b1;
                    n_state     = xosh_pkg::ST_IDLE;
                end
            end
            default: n_state = xosh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xosh_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_s0        <= xosh_pkg::SEED_K0;
            r_s1        <= xosh_pkg::SEED_K1;
            r_s2        <= xosh_pkg::SEED_K2;
            r_s3        <= xosh_pkg::SEED_K3;
            r_warm      <= '0;
            r_bit       <= '0;
            r_bounded   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_s0        <= n_s0;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            r_warm      <= n_warm;
            r_bit       <= n_bit;
            r_bounded   <= n_bounded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div   <= n_div;
        r_prod  <= n_prod;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_res   <= n_res;
        r_value <= n_value;
    end

endmodule

`default_nettype wire

### hw/rtl/xosh_checker.sv
// Port-level checks for the xoshiro256** generator, bound to its top level.
// Depends on xoshiro256_random_generator and xosh_pkg.
`default_nettype none

module xosh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_op,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [63:0] o_value
);

    logic in_take;
    logic no_result_op;
    logic result_op;

    assign in_take      = i_in_valid && !o_in_stall;
    assign no_result_op = (i_op == xosh_pkg::OP_SEED) || (i_op == xosh_pkg::OP_NONE);
    assign result_op    = (i_op == xosh_pkg::OP_RAW) || (i_op == xosh_pkg::OP_BOUNDED);

    // Reset leaves the block ready with nothing to deliver.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // A word that yields a result keeps the input stalled while it is worked on.
    a_busy_after_result_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && result_op) |=> o_in_stall)
        else $error("input not stalled after a raw or bounded word");

    // Seed and unused words never make a result appear.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && no_result_op && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared after a word that has none");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value)))
        else $error("stalled output word changed or dropped");

endmodule

bind xoshiro256_random_generator xosh_checker u_xosh_checker (.*);

`default_nettype wire

### tb/tb_xoshiro256_random_generator.sv
// Self-checking testbench for the xoshiro256** generator: directed and random words,
// with idle gaps on both channels, output back-pressure and a quiet-cycle watchdog.
// Depends on xosh_pkg and xoshiro256_random_generator.
module tb_xoshiro256_random_generator;

    localparam int WARMUP       = 20;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 300;

    localparam logic [63:0] GEN_K0 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] GEN_K1 = 64'h6C62_272E_07BB_0142;
    localparam logic [63:0] GEN_K2 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] GEN_K3 = 64'h94D0_49BB_1331_11EB;

    typedef struct {
        xosh_pkg::t_op op;
        logic [63:0]   value;
    } t_expected_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op         = xosh_pkg::OP_NONE;
    logic [63:0] i_seed_value = '0;
    logic [31:0] i_bound      = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [63:0] o_value;

    logic [63:0]    gen_words [4];
    t_expected_word pending_outputs [$];

    int error_count     = 0;
    int results_checked = 0;
    int quiet_cycles    = 0;
    int words_by_op [4] = '{0, 0, 0, 0};
    bit in_idle_on      = 1'b0;
    bit out_idle_on     = 1'b0;
    int out_hold_len    = 0;

    xoshiro256_random_generator #(
        .WARMUP_STEPS(WARMUP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_seed_value(i_seed_value),
        .i_bound     (i_bound),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value)
    );

    always #10 i_clk = ~i_clk;

    // Returns the scrambled output of the current state, then advances it.
    function automatic logic [63:0] gen_advance();
        logic [63:0] mult;
        logic [63:0] scrambled;
        logic [63:0] shifted;
        mult      = gen_words[1] * 64'd5;
        scrambled = {mult[56:0], mult[63:57]} * 64'd9;
        shifted   = gen_words[1] << 17;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= shifted;
        gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
        return scrambled;
    endfunction

    function automatic void gen_load(input logic [63:0] seed);
        gen_words[0] = seed ^ GEN_K0;
        gen_words[1] = seed ^ GEN_K1;
        gen_words[2] = seed ^ GEN_K2;
        gen_words[3] = seed ^ GEN_K3;
    endfunction

    function automatic void predict_word(input xosh_pkg::t_op op, input logic [63:0] seed,
                                         input logic [31:0] bnd);
        t_expected_word e;
        logic [63:0]    raw;
        int             k;
        case (op)
            xosh_pkg::OP_SEED: begin
                gen_load(seed);
                for (k = 0; k < WARMUP; k++) raw = gen_advance();
            end
            xosh_pkg::OP_RAW: begin
                e.op    = op;
                e.value = gen_advance();
                pending_outputs.push_back(e);
            end
            xosh_pkg::OP_BOUNDED: begin
                raw     = gen_advance();
                e.op    = op;
                // A zero bound passes the raw output through unchanged.
                e.value = (bnd == '0) ? raw : raw % {32'd0, bnd};
                pending_outputs.push_back(e);
            end
            default: ;
        endcase
        words_by_op[op]++;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    // Mostly zero, sometimes a few cycles, rarely a long stretch.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic send_word(input xosh_pkg::t_op op, input logic [63:0] seed,
                             input logic [31:0] bnd);
        int gap;
        gap = in_idle_on ? gap_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_seed_value <= seed;
        i_bound      <= bnd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(op, seed, bnd);
    endtask

    task automatic send_random_word();
        logic [63:0]   seed;
        logic [31:0]   bnd;
        int            pick;
        xosh_pkg::t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 8)       op = xosh_pkg::OP_SEED;
        else if (pick < 50) op = xosh_pkg::OP_RAW;
        else if (pick < 95) op = xosh_pkg::OP_BOUNDED;
        else                op = xosh_pkg::OP_NONE;
        seed = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       bnd = '0;
            1, 2:    bnd = $urandom_range(1, 16);
            3:       bnd = 32'd1 << $urandom_range(0, 31);
            4:       bnd = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: bnd = $urandom;
        endcase
        send_word(op, seed, bnd);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    // The first words after reset come from the seed constants with no warm-up.
    task automatic test_reset_state();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_word(xosh_pkg::OP_RAW, '1, '1);
        send_word(xosh_pkg::OP_RAW, '0, '0);
        send_word(xosh_pkg::OP_NONE, '1, '1);
        send_word(xosh_pkg::OP_RAW, '0, '0);
        wait_drained();
    endtask

    task automatic test_bound_extremes();
        send_word(xosh_pkg::OP_BOUNDED, '1, 32'd0);
        send_word(xosh_pkg::OP_BOUNDED, '1, 32'd1);
        send_word(xosh_pkg::OP_BOUNDED, '0, 32'd2);
        send_word(xosh_pkg::OP_BOUNDED, '1, 32'd3);
        send_word(xosh_pkg::OP_BOUNDED, '0, 32'h8000_0000);
        send_word(xosh_pkg::OP_BOUNDED, '1, 32'hFFFF_FFFF);
        send_word(xosh_pkg::OP_BOUNDED, '0, 32'hFFFF_FFFE);
        wait_drained();
    endtask

    task automatic test_seed_reload();
        send_word(xosh_pkg::OP_SEED, '0, '1);
        send_word(xosh_pkg::OP_RAW, '1, '1);
        send_word(xosh_pkg::OP_SEED, '1, '0);
        send_word(xosh_pkg::OP_BOUNDED, '0, 32'hFFFF_FFFF);
        send_word(xosh_pkg::OP_SEED, 64'hA5A5_5A5A_0F0F_F0F0, 32'd7);
        send_word(xosh_pkg::OP_NONE, '0, '0);
        send_word(xosh_pkg::OP_RAW, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
        send_word(xosh_pkg::OP_SEED, '0, '0);
        send_word(xosh_pkg::OP_SEED, '1, '1);
        send_word(xosh_pkg::OP_BOUNDED, '1, 32'd0);
        wait_drained();
    endtask

    task automatic test_random_words(input int count);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        repeat (count) send_random_word();
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        in_idle_on   = 1'b0;
        out_idle_on  = 1'b0;
        out_hold_len = LONG_HOLD;
        repeat (6) send_word(xosh_pkg::OP_RAW, {$urandom, $urandom}, $urandom);
        repeat (10) send_random_word();
        wait_drained();
    endtask

    task automatic test_full_rate(input int count);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        repeat (count) send_random_word();
        wait_drained();
    endtask

    initial begin : out_stall_driver
        int burst;
        int hold;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (out_hold_len > 0) begin
                hold         = out_hold_len;
                out_hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if (out_idle_on && burst == 0 && $urandom_range(0, 3) == 0)
                    burst = gap_length();
                if (out_idle_on && burst > 0) begin
                    i_out_stall <= 1'b1;
                    burst--;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_checker
        t_expected_word e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_outputs.size() == 0) begin
                note_error($sformatf("result %h arrived with nothing expected", o_value));
            end else begin
                e = pending_outputs.pop_front();
                results_checked++;
                if (o_value !== e.value)
                    note_error($sformatf("%s word: value expected %h, got %h",
                                         e.op.name(), e.value, o_value));
            end
        end
    end

    always @(posedge i_clk) begin : quiet_watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_outputs.size());
            $display("xoshiro256_random_generator regression: fail");
            $finish;
        end
    end

    initial begin
        gen_load('0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_bound_extremes();
        test_seed_reload();
        test_random_words(300);
        test_output_backpressure();
        test_full_rate(100);
        test_random_words(300);
        test_output_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_outputs.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_outputs.size()));

        $display("Sent %0d seed, %0d raw, %0d bounded and %0d unused-op words;",
                 words_by_op[xosh_pkg::OP_SEED], words_by_op[xosh_pkg::OP_RAW],
                 words_by_op[xosh_pkg::OP_BOUNDED], words_by_op[xosh_pkg::OP_NONE]);
        $display("checked %0d results under random gaps and back-pressure, %0d errors.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("xoshiro256_random_generator regression: pass");
        else
            $display("xoshiro256_random_generator regression: fail");
        $finish;
    end

endmodule
